// File: hdl/lfp_pkg.sv
package lfp_pkg;

  // Sensor width default and register reset values
  localparam int ADC_BITS_DEF = 10;
  localparam logic [63:0]        THRESH_RESET = 64'd549890400768;
  localparam logic signed [15:0] PROP_RESET   = 16'sd256;
  localparam logic signed [15:0] INTEG_RESET  = 16'sd0;
  localparam logic signed [15:0] DERIV_RESET  = 16'sd0;
  localparam logic signed [7:0]  BASE_RESET   = 8'sd40;
  localparam logic signed [7:0]  MIN_RESET    = 8'sd0;
  localparam logic signed [7:0]  MAX_RESET    = 8'sd100;

  // Register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_THRESH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROP   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTEG  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DERIV  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX    = 3'd6;

  // Steering error codes
  localparam logic signed [1:0] ERR_LEFT   = 2'sb01;
  localparam logic signed [1:0] ERR_CENTER = 2'sb00;
  localparam logic signed [1:0] ERR_RIGHT  = 2'sb11;

  // Datapath widths
  localparam int ELAPSED_W = 16;
  localparam int DIV_W     = 48;  // |integ_gain * integral| < 2^47
  localparam int DIVISOR_W = 16;
  localparam int PAIRS_W   = 5;
  localparam int DMAG_W    = 26;  // |deriv_gain * delta * 1000| < 2^26
  localparam int DNUM_W    = DMAG_W + 1;
  localparam int QI_W      = 38;
  localparam int QD_W      = DMAG_W + 1;
  localparam int CORR_W    = 40;
  localparam int SPEED_W   = 41;

  localparam logic [DIVISOR_W-1:0] MS_PER_S    = 16'd1000;
  localparam logic [PAIRS_W-1:0]   INTEG_PAIRS = PAIRS_W'(DIV_W / 2);
  localparam logic [PAIRS_W-1:0]   DERIV_PAIRS = PAIRS_W'(DMAG_W / 2);

  // x / 100 == (x * 5243) >> 19 for x < 2^15
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int          CENT_SHIFT = 19;

  // One classified item between front and back
  typedef struct packed {
    logic [3:0]           line_bits;
    logic [1:0]           err;
    logic [2:0]           delta;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 step;
  } lfp_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [PAIRS_W-1:0]   pairs;
  } div_req_t;

  // |percent| * 255 / 100, held at 255
  function automatic logic [7:0] duty_of(input logic [7:0] mag);
    logic [15:0] scaled;
    logic [28:0] prod;
    logic [9:0]  q;
    scaled = {mag, 8'd0} - {8'd0, mag};
    prod   = 29'(scaled) * 29'(CENT_RECIP);
    q      = prod[28:CENT_SHIFT];
    return (q > 10'd255) ? 8'hFF : q[7:0];
  endfunction

endpackage

// File: hdl/lfp_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
// Dividend comes MSB-aligned over 'pairs' bit pairs; dq holds the quotient when done is high.
module lfp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  lfp_pkg::div_req_t            req,
  output logic                         done,
  output logic [lfp_pkg::DIV_W-1:0]    quotient
);

  localparam int W  = lfp_pkg::DIV_W;
  localparam int DW = lfp_pkg::DIVISOR_W;

  logic [W-1:0]                 dq;
  logic [DW-1:0]                rem;
  logic [DW-1:0]                dv;
  logic [lfp_pkg::PAIRS_W-1:0]  cnt;
  logic                         busy;

  logic [DW:0]   r1, r2;
  logic          ge1, ge2;
  logic [DW-1:0] r1n, r2n;
  logic [W-1:0]  dq1, dq2;

  always_comb begin
    r1  = {rem, dq[W-1]};
    ge1 = (r1 >= {1'b0, dv});
    r1n = ge1 ? DW'(r1 - {1'b0, dv}) : r1[DW-1:0];
    dq1 = {dq[W-2:0], ge1};
    r2  = {r1n, dq1[W-1]};
    ge2 = (r2 >= {1'b0, dv});
    r2n = ge2 ? DW'(r2 - {1'b0, dv}) : r2[DW-1:0];
    dq2 = {dq1[W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.pairs;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == lfp_pkg::PAIRS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      rem <= '0;
      dv  <= req.divisor;
    end else if (busy) begin
      dq  <= dq2;
      rem <= r2n;
    end
  end

  assign quotient = dq;

endmodule

// File: hdl/lfp_front.sv
// Threshold compare, steering error and step classification per item.
module lfp_front #(
  parameter int ADC_BITS = lfp_pkg::ADC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [4*ADC_BITS-1:0]           thresholds,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  logic [ADC_BITS-1:0]             sample_outer_left,
  input  logic [ADC_BITS-1:0]             sample_inner_left,
  input  logic [ADC_BITS-1:0]             sample_inner_right,
  input  logic [ADC_BITS-1:0]             sample_outer_right,
  input  logic [lfp_pkg::ELAPSED_W-1:0]   elapsed_ms,
  output logic                            push_valid,
  input  logic                            push_ready,
  output lfp_pkg::lfp_item_t              push_item
);

  logic signed [1:0] last_err;
  logic              started;
  logic [3:0]        bits;
  logic signed [1:0] err;
  logic signed [2:0] delta;

  always_comb begin
    bits[0] = sample_outer_left  < thresholds[0*ADC_BITS +: ADC_BITS];
    bits[1] = sample_inner_left  < thresholds[1*ADC_BITS +: ADC_BITS];
    bits[2] = sample_inner_right < thresholds[2*ADC_BITS +: ADC_BITS];
    bits[3] = sample_outer_right < thresholds[3*ADC_BITS +: ADC_BITS];
    unique case (bits[2:1])
      2'b01:   err = lfp_pkg::ERR_LEFT;
      2'b10:   err = lfp_pkg::ERR_RIGHT;
      2'b11:   err = lfp_pkg::ERR_CENTER;
      default: err = last_err;
    endcase
    delta = 3'(err) - 3'(last_err);
    push_item.line_bits = bits;
    push_item.err       = err;
    push_item.delta     = delta;
    push_item.elapsed   = elapsed_ms;
    push_item.step      = started && (elapsed_ms != '0);
  end

  assign push_valid   = sample_valid;
  assign sample_ready = push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= lfp_pkg::ERR_CENTER;
      started  <= 1'b0;
    end else if (sample_valid && push_ready) begin
      last_err <= err;
      started  <= 1'b1;
    end
  end

endmodule

// File: hdl/lfp_queue.sv
// Two-entry item FIFO between front and back.
module lfp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  lfp_pkg::lfp_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output lfp_pkg::lfp_item_t pop_item
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  lfp_pkg::lfp_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;
  logic               do_push, do_pop;

  assign push_ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule

// File: hdl/lfp_back.sv
// PID sequencer: integral, products, two divisions (stepping items only), sum, clamp, drive.
module lfp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  lfp_pkg::lfp_item_t  item,
  input  logic signed [15:0]  prop_gain,
  input  logic signed [15:0]  integ_gain,
  input  logic signed [15:0]  deriv_gain,
  input  logic signed [7:0]   base_speed,
  input  logic signed [7:0]   min_speed,
  input  logic signed [7:0]   max_speed,
  output logic                drive_valid,
  input  logic                drive_ready,
  output logic [3:0]          line_bits,
  output logic signed [1:0]   steer_error,
  output logic                left_forward,
  output logic [7:0]          left_duty,
  output logic                right_forward,
  output logic [7:0]          right_duty
);

  localparam int W    = lfp_pkg::DIV_W;
  localparam int SW   = lfp_pkg::SPEED_W;
  localparam int CW   = lfp_pkg::CORR_W;
  localparam logic signed [lfp_pkg::DNUM_W-1:0] MS_SCALE = lfp_pkg::DNUM_W'(1000);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MULT   = 9'b000000010,
    S_STARTI = 9'b000000100,
    S_DIVI   = 9'b000001000,
    S_STARTD = 9'b000010000,
    S_DIVD   = 9'b000100000,
    S_SUM    = 9'b001000000,
    S_CLAMP  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state, state_next;

  lfp_pkg::lfp_item_t                    cur;
  logic signed [31:0]                    integral;
  logic signed [31:0]                    integral_next;
  logic signed [W-1:0]                   prod_i;
  logic signed [lfp_pkg::DNUM_W-1:0]     dnum;
  logic signed [lfp_pkg::QI_W-1:0]       qi;
  logic signed [lfp_pkg::QD_W-1:0]       qd;
  logic signed [CW-1:0]                  corr;
  logic signed [15:0]                    sp_l, sp_r;

  lfp_pkg::div_req_t                     req;
  logic                                  div_done;
  logic [W-1:0]                          quotient;

  logic [W-1:0]                          abs_i;
  logic [lfp_pkg::DMAG_W-1:0]            abs_d;
  logic signed [17:0]                    et;
  logic signed [33:0]                    acc;
  logic signed [17:0]                    dgd;
  logic signed [16:0]                    pe;
  logic signed [SW-1:0]                  base_q;
  logic                                  out_free;
  logic [8:0]                            wl, wr;

  function automatic logic signed [15:0] clamp_q(input logic signed [SW-1:0] s,
                                                 input logic signed [7:0]    lo,
                                                 input logic signed [7:0]    hi);
    logic signed [15:0] lo_q, hi_q;
    lo_q = {lo, 8'd0};
    hi_q = {hi, 8'd0};
    priority if (s < SW'(lo_q)) return lo_q;
    else if (s > SW'(hi_q))     return hi_q;
    else                        return s[15:0];
  endfunction

  // {forward, duty} from a clamped Q8.8 speed; percent truncates toward zero
  function automatic logic [8:0] wheel_drive(input logic signed [15:0] sp);
    logic [7:0] pct;
    logic [7:0] mag;
    pct = sp[15:8] + {7'd0, (sp[15] && (sp[7:0] != 8'd0))};
    mag = pct[7] ? 8'(-pct) : pct;
    return {(!pct[7] && (pct != 8'd0)), lfp_pkg::duty_of(mag)};
  endfunction

  lfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    // integral += e * t, saturated to 32 bits
    unique case ($signed(item.err))
      lfp_pkg::ERR_LEFT:  et = 18'(item.elapsed);
      lfp_pkg::ERR_RIGHT: et = -(18'(item.elapsed));
      default:            et = '0;
    endcase
    acc = 34'(integral) + 34'(et);
    if (acc[33] != acc[31]) integral_next = acc[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else                    integral_next = acc[31:0];

    unique case ($signed(cur.delta))
      -3'sd2:  dgd = -(18'(deriv_gain) <<< 1);
      -3'sd1:  dgd = -(18'(deriv_gain));
      3'sd1:   dgd = 18'(deriv_gain);
      3'sd2:   dgd = 18'(deriv_gain) <<< 1;
      default: dgd = '0;
    endcase

    unique case ($signed(cur.err))
      lfp_pkg::ERR_LEFT:  pe = 17'(prop_gain);
      lfp_pkg::ERR_RIGHT: pe = -(17'(prop_gain));
      default:            pe = '0;
    endcase

    abs_i  = prod_i[W-1] ? W'(-prod_i) : W'(prod_i);
    abs_d  = dnum[lfp_pkg::DNUM_W-1] ? lfp_pkg::DMAG_W'(-dnum) : dnum[lfp_pkg::DMAG_W-1:0];
    base_q = SW'($signed({base_speed, 8'd0}));
    out_free = !drive_valid || drive_ready;
    wl = wheel_drive(sp_l);
    wr = wheel_drive(sp_r);
  end

  always_comb begin
    req        = '0;
    state_next = state;
    unique case (state)
      S_IDLE:   if (item_valid) state_next = item.step ? S_MULT : S_SUM;
      S_MULT:   state_next = S_STARTI;
      S_STARTI: begin
        req.start    = 1'b1;
        req.dividend = abs_i;
        req.divisor  = lfp_pkg::MS_PER_S;
        req.pairs    = lfp_pkg::INTEG_PAIRS;
        state_next   = S_DIVI;
      end
      S_DIVI:   if (div_done) state_next = S_STARTD;
      S_STARTD: begin
        req.start    = 1'b1;
        req.dividend = {abs_d, (W - lfp_pkg::DMAG_W)'(0)};
        req.divisor  = cur.elapsed;
        req.pairs    = lfp_pkg::DERIV_PAIRS;
        state_next   = S_DIVD;
      end
      S_DIVD:   if (div_done) state_next = S_SUM;
      S_SUM:    state_next = S_CLAMP;
      S_CLAMP:  state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      integral    <= '0;
      drive_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && item_valid && item.step) integral <= integral_next;
      if (state == S_OUT && out_free) drive_valid <= 1'b1;
      else if (drive_ready)           drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) cur <= item;
    if (state == S_MULT) begin
      prod_i <= integ_gain * integral;
      dnum   <= lfp_pkg::DNUM_W'(dgd) * MS_SCALE;
    end
    if (state == S_DIVI && div_done) begin
      qi <= prod_i[W-1] ? -$signed({1'b0, quotient[lfp_pkg::QI_W-2:0]})
                        :  $signed({1'b0, quotient[lfp_pkg::QI_W-2:0]});
    end
    if (state == S_DIVD && div_done) begin
      qd <= dnum[lfp_pkg::DNUM_W-1] ? -$signed({1'b0, quotient[lfp_pkg::DMAG_W-1:0]})
                                    :  $signed({1'b0, quotient[lfp_pkg::DMAG_W-1:0]});
    end
    if (state == S_SUM) begin
      corr <= cur.step ? (CW'(pe) + CW'(qi) + CW'(qd)) : '0;
    end
    if (state == S_CLAMP) begin
      sp_l <= clamp_q(base_q - SW'(corr), min_speed, max_speed);
      sp_r <= clamp_q(base_q + SW'(corr), min_speed, max_speed);
    end
    if (state == S_OUT && out_free) begin
      line_bits     <= cur.line_bits;
      steer_error   <= cur.err;
      left_forward  <= wl[8];
      left_duty     <= wl[7:0];
      right_forward <= wr[8];
      right_duty    <= wr[7:0];
    end
  end

endmodule

// File: hdl/line_follow_pid_drive.sv
// Four-sensor PID line follower drive. Each item on the sample channel holds
// four ADC readings and the milliseconds since the previous item; each item
// yields exactly one result on the drive channel: on-line flags, the steering
// error (+1 line left, -1 line right, 0 centered, else the last error) and a
// direction bit plus 0..255 PWM duty for each wheel. The first item after
// reset, or one with elapsed_ms of zero, only records the error and drives
// at the clamped base speed. A stepping item in the back end uses the shared
// radix-4 divider twice, for the integral term over 1000 and the derivative
// term over elapsed_ms; a non-stepping item skips both divisions. The front
// classifies an item in the cycle it arrives and parks it in a two-entry
// queue, so until that queue is full the sample channel keeps taking items
// while the back end works and while a result waits on drive_ready.
// Registers sit on an APB-style port at 8-byte spacing (4-byte when the
// threshold word fits in 32 bits) and may be written only while the block
// is idle.
module line_follow_pid_drive #(
  parameter  int ADC_BITS   = lfp_pkg::ADC_BITS_DEF,
  localparam int THR_W      = 4 * ADC_BITS,
  localparam int DATA_W     = (THR_W > 32) ? 64 : 32,
  localparam int STRIDE_LOG = (DATA_W == 64) ? 3 : 2,
  localparam int ADDR_W     = STRIDE_LOG + lfp_pkg::REG_IDX_W
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // sample channel
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [ADC_BITS-1:0]           sample_outer_left,
  input  logic [ADC_BITS-1:0]           sample_inner_left,
  input  logic [ADC_BITS-1:0]           sample_inner_right,
  input  logic [ADC_BITS-1:0]           sample_outer_right,
  input  logic [lfp_pkg::ELAPSED_W-1:0] elapsed_ms,
  // drive channel
  output logic                          drive_valid,
  input  logic                          drive_ready,
  output logic [3:0]                    line_bits,
  output logic signed [1:0]             steer_error,
  output logic                          left_forward,
  output logic [7:0]                    left_duty,
  output logic                          right_forward,
  output logic [7:0]                    right_duty
);

  // Configuration registers
  logic [THR_W-1:0]   thresholds;
  logic signed [15:0] prop_gain;
  logic signed [15:0] integ_gain;
  logic signed [15:0] deriv_gain;
  logic signed [7:0]  base_speed;
  logic signed [7:0]  min_speed;
  logic signed [7:0]  max_speed;

  logic [lfp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_write;

  // No wait states; the low address bits inside a register slot are ignored
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:STRIDE_LOG];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresholds <= lfp_pkg::THRESH_RESET[THR_W-1:0];
      prop_gain  <= lfp_pkg::PROP_RESET;
      integ_gain <= lfp_pkg::INTEG_RESET;
      deriv_gain <= lfp_pkg::DERIV_RESET;
      base_speed <= lfp_pkg::BASE_RESET;
      min_speed  <= lfp_pkg::MIN_RESET;
      max_speed  <= lfp_pkg::MAX_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        lfp_pkg::REG_THRESH: thresholds <= pwdata[THR_W-1:0];
        lfp_pkg::REG_PROP:   prop_gain  <= pwdata[15:0];
        lfp_pkg::REG_INTEG:  integ_gain <= pwdata[15:0];
        lfp_pkg::REG_DERIV:  deriv_gain <= pwdata[15:0];
        lfp_pkg::REG_BASE:   base_speed <= pwdata[7:0];
        lfp_pkg::REG_MIN:    min_speed  <= pwdata[7:0];
        lfp_pkg::REG_MAX:    max_speed  <= pwdata[7:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // Read-back, zero-extended raw register bits
  always_comb begin
    unique case (reg_idx)
      lfp_pkg::REG_THRESH: prdata = DATA_W'(thresholds);
      lfp_pkg::REG_PROP:   prdata = DATA_W'($unsigned(prop_gain));
      lfp_pkg::REG_INTEG:  prdata = DATA_W'($unsigned(integ_gain));
      lfp_pkg::REG_DERIV:  prdata = DATA_W'($unsigned(deriv_gain));
      lfp_pkg::REG_BASE:   prdata = DATA_W'($unsigned(base_speed));
      lfp_pkg::REG_MIN:    prdata = DATA_W'($unsigned(min_speed));
      lfp_pkg::REG_MAX:    prdata = DATA_W'($unsigned(max_speed));
      default:             prdata = '0;
    endcase
  end

  // Front -> queue -> back
  logic               push_valid, push_ready;
  lfp_pkg::lfp_item_t push_item;
  logic               pop_valid, pop_ready;
  lfp_pkg::lfp_item_t pop_item;

  // Front tracks the last error and the started flag itself, so each queued
  // item already carries its error, error delta and whether it is a PID step.
  lfp_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .thresholds         (thresholds),
    .sample_valid       (sample_valid),
    .sample_ready       (sample_ready),
    .sample_outer_left  (sample_outer_left),
    .sample_inner_left  (sample_inner_left),
    .sample_inner_right (sample_inner_right),
    .sample_outer_right (sample_outer_right),
    .elapsed_ms         (elapsed_ms),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_item          (push_item)
  );

  lfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back end owns the saturating integral and the output register
  lfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (pop_valid),
    .item_ready    (pop_ready),
    .item          (pop_item),
    .prop_gain     (prop_gain),
    .integ_gain    (integ_gain),
    .deriv_gain    (deriv_gain),
    .base_speed    (base_speed),
    .min_speed     (min_speed),
    .max_speed     (max_speed),
    .drive_valid   (drive_valid),
    .drive_ready   (drive_ready),
    .line_bits     (line_bits),
    .steer_error   (steer_error),
    .left_forward  (left_forward),
    .left_duty     (left_duty),
    .right_forward (right_forward),
    .right_duty    (right_duty)
  );

endmodule

// File: test/pid_drive_checker.sv
`timescale 1ns / 1ps

module pid_drive_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        sample_valid,
  input  logic        sample_ready,
  input  logic [9:0]  sample_outer_left,
  input  logic [9:0]  sample_inner_left,
  input  logic [9:0]  sample_inner_right,
  input  logic [9:0]  sample_outer_right,
  input  logic [15:0] elapsed_ms,
  input  logic        drive_valid,
  input  logic        drive_ready,
  input  logic [3:0]  line_bits,
  input  logic [1:0]  steer_error,
  input  logic        left_forward,
  input  logic [7:0]  left_duty,
  input  logic        right_forward,
  input  logic [7:0]  right_duty,
  output int          mismatches,
  output int          drives_due
);

  typedef struct packed {
    logic [3:0] line_bits;
    logic [1:0] steer_error;
    logic       left_forward;
    logic [7:0] left_duty;
    logic       right_forward;
    logic [7:0] right_duty;
  } wheel_cmd_t;

  localparam longint INTEG_MAX = 64'sh7FFF_FFFF;
  localparam longint INTEG_MIN = -64'sh8000_0000;

  // register mirror
  logic [39:0] thresholds;
  longint      kp, ki, kd;
  longint      base_pct, min_pct, max_pct;

  // controller state
  logic [1:0]  last_err;
  longint      integral;
  logic        started;

  wheel_cmd_t  due_drives[$];
  int          n_bad;

  // clamp, then whole percent -> direction and 0..255 duty
  function automatic void wheel(input longint q, output logic fwd, output logic [7:0] duty);
    longint pct;
    longint mag;
    if (q < min_pct * 256) q = min_pct * 256;
    else if (q > max_pct * 256) q = max_pct * 256;
    pct = q / 256;
    mag = (pct < 0) ? -pct : pct;
    mag = mag * 255 / 100;
    fwd = (pct > 0);
    duty = (mag > 255) ? 8'hFF : mag[7:0];
  endfunction

  function automatic wheel_cmd_t pid_step(input logic [39:0] smp, input logic [15:0] t);
    wheel_cmd_t r;
    longint     e;
    longint     acc;
    longint     corr;
    r = '0;
    for (int i = 0; i < 4; i++)
      r.line_bits[i] = smp[i*10 +: 10] < thresholds[i*10 +: 10];
    if (r.line_bits[1] && !r.line_bits[2]) r.steer_error = lfp_pkg::ERR_LEFT;
    else if (!r.line_bits[1] && r.line_bits[2]) r.steer_error = lfp_pkg::ERR_RIGHT;
    else if (r.line_bits[1]) r.steer_error = lfp_pkg::ERR_CENTER;
    else r.steer_error = last_err;
    e = $signed(r.steer_error);
    corr = 0;
    if (started && t != 0) begin
      acc = integral + e * longint'(t);
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      else if (acc < INTEG_MIN) acc = INTEG_MIN;
      integral = acc;
      corr = kp * e + (ki * integral) / 1000
           + (kd * (e - longint'($signed(last_err))) * 1000) / longint'(t);
    end
    started = 1'b1;
    last_err = r.steer_error;
    wheel(base_pct * 256 - corr, r.left_forward, r.left_duty);
    wheel(base_pct * 256 + corr, r.right_forward, r.right_duty);
    return r;
  endfunction

  function automatic string show(input wheel_cmd_t c);
    return $sformatf("bits=%b err=%0d left=%0d/%0d right=%0d/%0d", c.line_bits,
                     $signed(c.steer_error), c.left_forward, c.left_duty,
                     c.right_forward, c.right_duty);
  endfunction

  always @(posedge clk) begin : watch
    wheel_cmd_t got;
    wheel_cmd_t want;
    if (rst) begin
      thresholds = lfp_pkg::THRESH_RESET[39:0];
      kp = lfp_pkg::PROP_RESET;
      ki = lfp_pkg::INTEG_RESET;
      kd = lfp_pkg::DERIV_RESET;
      base_pct = lfp_pkg::BASE_RESET;
      min_pct = lfp_pkg::MIN_RESET;
      max_pct = lfp_pkg::MAX_RESET;
      last_err = lfp_pkg::ERR_CENTER;
      integral = 0;
      started = 1'b0;
      due_drives.delete();
      n_bad = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          lfp_pkg::REG_THRESH: thresholds = pwdata[39:0];
          lfp_pkg::REG_PROP:   kp = $signed(pwdata[15:0]);
          lfp_pkg::REG_INTEG:  ki = $signed(pwdata[15:0]);
          lfp_pkg::REG_DERIV:  kd = $signed(pwdata[15:0]);
          lfp_pkg::REG_BASE:   base_pct = $signed(pwdata[7:0]);
          lfp_pkg::REG_MIN:    min_pct = $signed(pwdata[7:0]);
          lfp_pkg::REG_MAX:    max_pct = $signed(pwdata[7:0]);
          default: ;
        endcase
      end
      if (sample_valid && sample_ready)
        due_drives.push_back(pid_step({sample_outer_right, sample_inner_right,
                                       sample_inner_left, sample_outer_left}, elapsed_ms));
      if (drive_valid && drive_ready) begin
        got = {line_bits, steer_error, left_forward, left_duty, right_forward, right_duty};
        if (due_drives.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%t drive item with nothing expected: %s", $realtime, show(got));
        end else begin
          want = due_drives.pop_front();
          if (want != got) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%t drive mismatch: want %s got %s", $realtime, show(want), show(got));
          end
        end
      end
    end
    drives_due <= due_drives.size();
    mismatches <= n_bad;
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

  // receiver hold-off long enough to back the block up into the sample channel
  localparam int HOLD_CYCLES    = 400;
  // settle time before register writes and before the verdict
  localparam int SETTLE         = 60;
  // cycles without any accepted item or register write before giving up
  localparam int WATCHDOG_LIMIT = 5000;
  // index past the end of the register map, writes must be dropped
  localparam logic [2:0] REG_SPARE = 3'd7;

  logic        clk;
  logic        rst;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  logic        sample_valid;
  logic        sample_ready;
  logic [9:0]  sample_outer_left;
  logic [9:0]  sample_inner_left;
  logic [9:0]  sample_inner_right;
  logic [9:0]  sample_outer_right;
  logic [15:0] elapsed_ms;

  logic        drive_valid;
  logic        drive_ready;
  logic [3:0]  line_bits;
  logic signed [1:0] steer_error;
  logic        left_forward;
  logic [7:0]  left_duty;
  logic        right_forward;
  logic [7:0]  right_duty;

  int          mismatches;
  int          drives_due;
  int          quiet_cycles;

  logic        calm;        // no idling on either side once set
  int          hold_req;    // bumped by stimulus to ask for one long receiver hold-off
  logic [39:0] thr_now;     // thresholds as last written, steers sample picking

  line_follow_pid_drive u_top (.*);

  pid_drive_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any accepted item or register write restarts the count.
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (drive_valid && drive_ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive-side receiver: short random stalls, plus one long hold-off per
  // request from the stimulus so the two-entry queue fills and sample_ready drops.
  initial begin : drain
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    drive_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_req) begin
        holds_done = hold_req;
        drive_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        drive_ready <= 1'b1;
      end else if (stall_left > 0) begin
        drive_ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        // start a stall burst; stall_left holds the rest of it
        drive_ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        drive_ready <= 1'b1;
      end
    end
  end

  // Mostly samples placed on one side of their own threshold so the inner
  // pair walks through left/right/center/lost; some rails and raw noise.
  function automatic logic [9:0] pick_sample(input logic [9:0] th);
    case ($urandom_range(0, 9))
      0:       return 10'd0;
      1:       return 10'h3FF;
      2, 3:    return 10'($urandom());
      4, 5, 6: return (th == 10'd0) ? 10'd0 : 10'($urandom_range(0, th - 1));
      default: return 10'($urandom_range(th, 1023));
    endcase
  endfunction

  // Mostly short real steps; zero (no step), one, the top value and raw noise
  // show up now and then.
  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(0, 15))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      3:       return 16'd1;
      default: return 16'($urandom_range(1, 60));
    endcase
  endfunction

  // Present one item and hold it until accepted. An optional idle burst goes
  // in front; valid is otherwise left high into the next item.
  task automatic offer(input logic [9:0] s_ol, input logic [9:0] s_il,
                       input logic [9:0] s_ir, input logic [9:0] s_or,
                       input logic [15:0] t);
    if (!calm && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample_valid       <= 1'b1;
    sample_outer_left  <= s_ol;
    sample_inner_left  <= s_il;
    sample_inner_right <= s_ir;
    sample_outer_right <= s_or;
    elapsed_ms         <= t;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  // Stop offering, wait for every expected drive item, then let the back end settle.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (drives_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup then access phase; psel stays up across back-to-back writes and
  // the caller drops it after the last one.
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [39:0] th, input logic [15:0] g_p,
                          input logic [15:0] g_i, input logic [15:0] g_d,
                          input logic [7:0] sp_base, input logic [7:0] sp_min,
                          input logic [7:0] sp_max);
    wait_drained();
    reg_write(lfp_pkg::REG_THRESH, 64'(th));
    reg_write(lfp_pkg::REG_PROP, 64'(g_p));
    reg_write(lfp_pkg::REG_INTEG, 64'(g_i));
    reg_write(lfp_pkg::REG_DERIV, 64'(g_d));
    reg_write(lfp_pkg::REG_BASE, 64'(sp_base));
    reg_write(lfp_pkg::REG_MIN, 64'(sp_min));
    reg_write(lfp_pkg::REG_MAX, 64'(sp_max));
    // unmapped index with all-random data; must change nothing
    reg_write(REG_SPARE, {$urandom(), $urandom()});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    thr_now = th;
  endtask

  initial begin : stimulus
    logic [39:0] th;
    logic [15:0] kp, ki, kd;
    logic [7:0]  base, mn, mx;
    int          n_items;

    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    sample_valid       = 1'b0;
    sample_outer_left  = '0;
    sample_inner_left  = '0;
    sample_inner_right = '0;
    sample_outer_right = '0;
    elapsed_ms         = '0;
    calm               = 1'b0;
    hold_req           = 0;
    thr_now            = lfp_pkg::THRESH_RESET[39:0];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset register values (thresholds 512/360/128/512, kp 1.0)
    offer(10'd0, 10'd0, 10'h3FF, 10'h3FF, 16'd5);         // first item: record only
    offer(10'h3FF, 10'h3FF, 10'd0, 10'd0, 16'd10);        // swing right, delta -2
    offer(10'd0, 10'd0, 10'd0, 10'd0, 16'hFFFF);          // all on, centered
    offer(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 16'd1);     // lost, keeps center
    offer(10'd0, 10'd0, 10'h3FF, 10'd0, 16'd0);           // zero time: no step
    offer(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 16'd7);     // lost, keeps left
    offer(10'h3FF, 10'h3FF, 10'd0, 10'h3FF, 16'hFFFF);    // right, longest step
    offer(10'd512, 10'd360, 10'd128, 10'd512, 16'd3);     // equal to threshold: off line
    offer(10'd511, 10'd359, 10'd127, 10'd511, 16'd3);     // one below: on line
    offer(10'd0, 10'h3FF, 10'h3FF, 10'd0, 16'hFFFF);      // outer only, lost

    // --- directed, gains at the rails, speeds at +-100
    set_regs({4{10'h3FF}}, 16'h7FFF, 16'h7FFF, 16'h8000, 8'sd100, -8'sd100, 8'sd100);
    offer(10'd0, 10'd0, 10'h3FF, 10'd0, 16'd1);
    offer(10'd0, 10'h3FF, 10'd0, 10'd0, 16'd1);           // derivative over 1 ms
    offer(10'd0, 10'd0, 10'h3FF, 10'd0, 16'hFFFF);
    offer(10'd0, 10'd0, 10'd0, 10'd0, 16'hFFFF);
    offer(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 16'd2);
    offer(10'd0, 10'h3FF, 10'd0, 10'd0, 16'd0);
    offer(10'd0, 10'd0, 10'h3FF, 10'd0, 16'd1000);

    // --- directed, min above max: min clamp takes precedence
    set_regs({4{10'h3FF}}, 16'd256, 16'd0, 16'd0, 8'sd0, 8'sd50, -8'sd50);
    offer(10'd0, 10'd0, 10'h3FF, 10'd0, 16'd10);
    offer(10'd0, 10'h3FF, 10'd0, 10'd0, 16'd10);
    offer(10'd0, 10'd0, 10'd0, 10'd0, 16'd10);

    // --- directed, speed registers past +-100 so duty pins at 255
    set_regs({4{10'h3FF}}, 16'h7FFF, 16'd0, 16'd0, 8'sd127, -8'sd128, 8'sd127);
    offer(10'd0, 10'd0, 10'h3FF, 10'd0, 16'd5);
    offer(10'd0, 10'h3FF, 10'd0, 10'd0, 16'd5);
    offer(10'd0, 10'd0, 10'd0, 10'd0, 16'd5);

    // --- random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      // moderate setting: corrections of a few to tens of percent
      th   = {8'($urandom_range(0, 255)), 32'($urandom())};
      kp   = 16'($urandom_range(0, 12000) - 6000);
      ki   = 16'($urandom_range(0, 4000) - 2000);
      kd   = 16'($urandom_range(0, 400) - 200);
      base = 8'($urandom_range(0, 200) - 100);
      mn   = 8'($urandom_range(0, 100) - 100);
      mx   = 8'($urandom_range(0, 100));
      case (ph)
        0: begin
          th = {4{10'h3FF}};
          kp = 16'h8000;
          ki = 16'h7FFF;
          kd = 16'h7FFF;
          base = 8'sd100;
          mn = -8'sd100;
          mx = 8'sd100;
        end
        1: begin
          // nothing is ever on the line: error sticks at its last value
          th = '0;
          kp = 16'h7FFF;
          ki = 16'h8000;
          kd = 16'h8000;
          base = -8'sd100;
        end
        3: begin
          // every register bit random, speeds included
          kp = 16'($urandom());
          ki = 16'($urandom());
          kd = 16'($urandom());
          base = 8'($urandom());
          mn = 8'($urandom());
          mx = 8'($urandom());
        end
        4: begin
          mn = 8'($urandom_range(10, 100));
          mx = -mn;
        end
        default: ;
      endcase
      set_regs(th, kp, ki, kd, base, mn, mx);
      if (ph == 2 || ph == 5) hold_req++;
      n_items = (ph == 1) ? 80 : 190;
      for (int k = 0; k < n_items; k++) begin
        if (ph == 7 && k == n_items / 2) calm = 1'b1;
        offer(pick_sample(thr_now[9:0]), pick_sample(thr_now[19:10]),
              pick_sample(thr_now[29:20]), pick_sample(thr_now[39:30]), pick_elapsed());
      end
    end

    wait_drained();
    if (mismatches == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
